// ===== rtl/sfr_pkg.sv =====
package sfr_pkg;

    localparam int SFR_MAX_LEN = 8;
    localparam int OUT_DEPTH = 8;
    localparam int CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;
    localparam int MATCH_W = 16;
    localparam logic [MATCH_W-1:0] MATCH_MAX = {MATCH_W{1'b1}};

    typedef enum logic [1:0] {
        REG_SEARCH_PATTERN     = 2'd0,
        REG_SEARCH_LENGTH      = 2'd1,
        REG_REPLACEMENT_TEXT   = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        WIN_HOLD   = 2'd0,
        WIN_SHIFT1 = 2'd1,
        WIN_SHIFT2 = 2'd2
    } win_op_t;

    typedef struct packed {
        logic    append;
        win_op_t op;
    } win_ctl_t;

    typedef struct packed {
        logic load;
        logic shift;
    } out_ctl_t;

endpackage

// ===== rtl/sfr_win_cell.sv =====
module sfr_win_cell
    import sfr_pkg::*;
(
    input  logic       clk,
    input  win_ctl_t   ctl,
    input  logic [7:0] in_byte,
    input  logic [7:0] pat_byte,
    input  logic [7:0] next1,
    input  logic [7:0] next2,
    output logic [7:0] cur,
    output logic       eq
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // The incoming byte lands here when this cell is the first free one.
    assign cur = ctl.append ? in_byte : byte_reg;
    assign eq  = (cur == pat_byte);

    always_comb
    begin
        case (ctl.op)
            WIN_SHIFT1: byte_next = next1;
            WIN_SHIFT2: byte_next = next2;
            default:    byte_next = cur;
        endcase
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

// ===== rtl/sfr_out_cell.sv =====
module sfr_out_cell
    import sfr_pkg::*;
(
    input  logic       clk,
    input  out_ctl_t   ctl,
    input  logic [7:0] load_byte,
    input  logic [7:0] next_byte,
    output logic [7:0] held
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        if (ctl.load)
        begin
            byte_next = load_byte;
        end
        else if (ctl.shift)
        begin
            byte_next = next_byte;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign held = byte_reg;

endmodule

// ===== rtl/stream_find_replace_core.sv =====
// Streaming find-and-replace: every leftmost, non-overlapping occurrence of the search pattern
// is replaced by the replacement text, and the final result of each text carries the match
// count and a none-found flag. A byte that yields at most one result is accepted every cycle
// unless out_ready holds the output; a request that yields n results (a replacement of n bytes,
// or the flush on the last byte) holds the input until all but the last have left the buffer,
// one byte a cycle while out_ready allows, through an output register. No clearing pass follows reset.
module stream_find_replace_core
    import sfr_pkg::*;
#(
    parameter int MAX_LEN = SFR_MAX_LEN
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                has_byte,
    output logic                out_last,
    output logic [MATCH_W-1:0]  match_total,
    output logic                none_found
);

    localparam int FILL_W = $clog2(MAX_LEN + 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_LEN);

    logic [63:0]          pattern_reg;
    logic [3:0]           slen_reg;
    logic [63:0]          rtext_reg;
    logic [3:0]           rlen_reg;
    logic                 cfg_wr;
    reg_idx_t             cfg_idx;

    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [MATCH_W-1:0]   match_cnt_reg;
    logic [MATCH_W-1:0]   match_cnt_next;
    logic [CNT_W-1:0]     ocnt_reg;
    logic [CNT_W-1:0]     ocnt_next;
    logic                 batch_last_reg;
    logic                 batch_marker_reg;
    logic [MATCH_W-1:0]   batch_total_reg;
    logic                 ovalid_reg;
    logic                 ovalid_next;
    logic [7:0]           obyte_reg;
    logic                 ohas_reg;
    logic                 olast_reg;
    logic [MATCH_W-1:0]   ototal_reg;
    logic                 onone_reg;

    logic [FILL_W-1:0]    len;
    logic [CNT_W-1:0]     rlen;
    logic [FILL_W-1:0]    fill_a;
    logic [FILL_W-1:0]    fill_m1;
    logic [MAX_LEN-1:0]   eq_vec;
    logic [MAX_LEN-1:0]   pass_vec;
    logic                 matched;
    logic [1:0]           npop;
    logic [CNT_W-1:0]     n_batch;
    logic                 marker;
    logic [MATCH_W-1:0]   cnt_new;
    logic                 accept;
    logic                 move;
    win_op_t              win_op;
    out_ctl_t             out_ctl;

    logic [7:0]           cur [MAX_LEN];
    logic [7:0]           held [OUT_DEPTH];

    // Configuration registers.
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            slen_reg    <= '0;
            rtext_reg   <= '0;
            rlen_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SEARCH_PATTERN:     pattern_reg <= pwdata;
                REG_SEARCH_LENGTH:      slen_reg    <= pwdata[3:0];
                REG_REPLACEMENT_TEXT:   rtext_reg   <= pwdata;
                REG_REPLACEMENT_LENGTH: rlen_reg    <= pwdata[3:0];
                default:                pattern_reg <= pattern_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SEARCH_PATTERN:     prdata = pattern_reg;
            REG_SEARCH_LENGTH:      prdata = {60'd0, slen_reg};
            REG_REPLACEMENT_TEXT:   prdata = rtext_reg;
            REG_REPLACEMENT_LENGTH: prdata = {60'd0, rlen_reg};
            default:                prdata = '0;
        endcase
    end

    // Effective lengths, with oversized values clamped.
    assign len  = (slen_reg > 4'(MAX_LEN)) ? FILL_MAX : FILL_W'(slen_reg);
    assign rlen = (CNT_W'(rlen_reg) > CNT_W'(OUT_DEPTH)) ? CNT_W'(OUT_DEPTH)
                                                          : CNT_W'(rlen_reg);

    // Handshake. The buffer may be reloaded once its last byte moves on.
    assign move     = (ocnt_reg != '0) && (!ovalid_reg || out_ready);
    assign in_ready = (ocnt_reg == '0) || ((ocnt_reg == CNT_W'(1)) && move);
    assign accept   = in_valid && in_ready;

    // Window chain.
    assign fill_a  = (fill_reg < FILL_MAX) ? FILL_W'(fill_reg + 1'b1) : fill_reg;
    assign fill_m1 = FILL_W'(fill_a - 1'b1);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LEN; gi++)
        begin : g_win
            win_ctl_t   ctl;
            logic [7:0] nb1;
            logic [7:0] nb2;

            assign ctl.append = accept && (fill_reg == FILL_W'(gi));
            assign ctl.op     = accept ? win_op : WIN_HOLD;

            if (gi + 1 < MAX_LEN)
            begin : g_nb1
                assign nb1 = cur[gi+1];
            end
            else
            begin : g_nb1_end
                assign nb1 = 8'h00;
            end

            if (gi + 2 < MAX_LEN)
            begin : g_nb2
                assign nb2 = cur[gi+2];
            end
            else
            begin : g_nb2_end
                assign nb2 = 8'h00;
            end

            sfr_win_cell u_cell (
                .clk      (clk),
                .ctl      (ctl),
                .in_byte  (in_byte),
                .pat_byte (pattern_reg[8*gi +: 8]),
                .next1    (nb1),
                .next2    (nb2),
                .cur      (cur[gi]),
                .eq       (eq_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < MAX_LEN; i++)
        begin
            pass_vec[i] = eq_vec[i] || (FILL_W'(i) >= len);
        end
    end

    assign matched = (len != '0) && (fill_a == len) && (&pass_vec);

    always_comb
    begin
        if (fill_a > len)
        begin
            npop = (fill_m1 > len) ? 2'd2 : 2'd1;
        end
        else if ((fill_a == len) && (len != '0) && !matched)
        begin
            npop = 2'd1;
        end
        else
        begin
            npop = 2'd0;
        end
    end

    always_comb
    begin
        case (npop)
            2'd1:    win_op = WIN_SHIFT1;
            2'd2:    win_op = WIN_SHIFT2;
            default: win_op = WIN_HOLD;
        endcase
    end

    always_comb
    begin
        if (in_last || matched)
        begin
            fill_next = '0;
        end
        else
        begin
            fill_next = FILL_W'(fill_a - FILL_W'(npop));
        end
    end

    assign cnt_new = (matched && (match_cnt_reg != MATCH_MAX))
                   ? MATCH_W'(match_cnt_reg + 1'b1) : match_cnt_reg;
    assign match_cnt_next = in_last ? '0 : cnt_new;

    // Results of one request: the replacement, or the oldest bytes of the window.
    always_comb
    begin
        if (matched)
        begin
            n_batch = rlen;
        end
        else if (in_last)
        begin
            n_batch = CNT_W'(fill_a);
        end
        else
        begin
            n_batch = CNT_W'(npop);
        end
    end

    assign marker = in_last && (n_batch == '0);

    // Output buffer chain.
    assign out_ctl.load  = accept;
    assign out_ctl.shift = move;

    generate
        for (gi = 0; gi < OUT_DEPTH; gi++)
        begin : g_out
            logic [7:0] win_byte;
            logic [7:0] nb;

            if (gi < MAX_LEN)
            begin : g_wb
                assign win_byte = cur[gi];
            end
            else
            begin : g_wb_none
                assign win_byte = 8'h00;
            end

            if (gi + 1 < OUT_DEPTH)
            begin : g_nb
                assign nb = held[gi+1];
            end
            else
            begin : g_nb_end
                assign nb = 8'h00;
            end

            sfr_out_cell u_cell (
                .clk       (clk),
                .ctl       (out_ctl),
                .load_byte (matched ? rtext_reg[8*gi +: 8] : win_byte),
                .next_byte (nb),
                .held      (held[gi])
            );
        end
    endgenerate

    always_comb
    begin
        if (accept)
        begin
            ocnt_next = marker ? CNT_W'(1) : n_batch;
        end
        else if (move)
        begin
            ocnt_next = CNT_W'(ocnt_reg - 1'b1);
        end
        else
        begin
            ocnt_next = ocnt_reg;
        end
    end

    always_comb
    begin
        if (move)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
        else
        begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg         <= '0;
            match_cnt_reg    <= '0;
            ocnt_reg         <= '0;
            ovalid_reg       <= 1'b0;
            batch_last_reg   <= 1'b0;
            batch_marker_reg <= 1'b0;
            batch_total_reg  <= '0;
        end
        else
        begin
            ocnt_reg   <= ocnt_next;
            ovalid_reg <= ovalid_next;
            if (accept)
            begin
                fill_reg         <= fill_next;
                match_cnt_reg    <= match_cnt_next;
                batch_last_reg   <= in_last;
                batch_marker_reg <= marker;
                batch_total_reg  <= cnt_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            obyte_reg  <= batch_marker_reg ? 8'h00 : held[0];
            ohas_reg   <= !batch_marker_reg;
            olast_reg  <= batch_last_reg && (ocnt_reg == CNT_W'(1));
            ototal_reg <= batch_total_reg;
            onone_reg  <= batch_last_reg && (ocnt_reg == CNT_W'(1))
                          && (batch_total_reg == '0);
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_byte    = obyte_reg;
    assign has_byte    = ohas_reg;
    assign out_last    = olast_reg;
    assign match_total = ototal_reg;
    assign none_found  = onone_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (ocnt_reg == '0) || (ocnt_reg == CNT_W'(1)))
        else $error("Request accepted while the output buffer still held several bytes.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (match_cnt_reg == '0) && (fill_reg == '0))
        else $error("Match counter or window not cleared after the last byte.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_byte) |-> (out_last && (out_byte == 8'h00)))
        else $error("Empty end marker that is not the final result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && none_found) |-> (out_last && (match_total == '0)))
        else $error("None-found flag raised with a non-zero count or before the end.");

    assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= CNT_W'(OUT_DEPTH))
        else $error("Output buffer count beyond its depth.");

endmodule

// ===== test/testbench.sv =====
module testbench
    import sfr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 400000;
    localparam int SETTLE = 6;
    localparam int RANDOM_REQUESTS = 420;

    typedef struct packed {
        logic [7:0]         text_byte;
        logic               has;
        logic               fin;
        logic [MATCH_W-1:0] total;
        logic               none;
    } result_t;

    typedef enum logic {
        STEP_WRITE,
        STEP_BYTE
    } step_kind_t;

    typedef struct {
        step_kind_t  kind;
        reg_idx_t    idx;
        logic [63:0] value;
        logic [7:0]  text_byte;
        logic        fin;
        bit          typed;
        result_t     want;
    } step_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          in_byte;
    logic                in_last;
    logic                out_valid;
    logic                out_ready;
    logic [7:0]          out_byte;
    logic                has_byte;
    logic                out_last;
    logic [MATCH_W-1:0]  match_total;
    logic                none_found;

    // Mirror of the block's window, counter and registers.
    logic [7:0]         held [SFR_MAX_LEN];
    int unsigned        held_count;
    logic [MATCH_W-1:0] replaced_count;
    logic [63:0]        find_bytes;
    logic [3:0]         find_len;
    logic [63:0]        swap_bytes;
    logic [3:0]         swap_len;

    result_t     step_out[$];
    result_t     expected_text[$];
    step_t       directed[$];
    int          mismatches;
    int          items_sent;
    int          cycles;
    int          hold_left;
    bit          hold_asked;
    bit          calm;
    int          phase;
    int          base;

    stream_find_replace_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .out_last    (out_last),
        .match_total (match_total),
        .none_found  (none_found)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("FAIL stream_find_replace_core");
            $finish;
        end
    end

    // The long hold-off is counted here so that the sender keeps offering requests meanwhile.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_asked)
        begin
            hold_asked = 1'b0;
            hold_left = 300;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_text.size() == 0)
            begin
                $error("unexpected result: out_byte %h has_byte %b out_last %b",
                       out_byte, has_byte, out_last);
                mismatches++;
            end
            else
            begin
                exp_r = expected_text.pop_front();
                if (out_byte !== exp_r.text_byte)
                begin
                    $error("out_byte: expected %h, got %h", exp_r.text_byte, out_byte);
                    mismatches++;
                end
                if (has_byte !== exp_r.has)
                begin
                    $error("has_byte: expected %b, got %b", exp_r.has, has_byte);
                    mismatches++;
                end
                if (out_last !== exp_r.fin)
                begin
                    $error("out_last: expected %b, got %b", exp_r.fin, out_last);
                    mismatches++;
                end
                if (match_total !== exp_r.total)
                begin
                    $error("match_total: expected %0d, got %0d", exp_r.total, match_total);
                    mismatches++;
                end
                if (none_found !== exp_r.none)
                begin
                    $error("none_found: expected %b, got %b", exp_r.none, none_found);
                    mismatches++;
                end
            end
        end
    end

    function automatic void emit_byte(input logic [7:0] b, input logic has);
        result_t r;
        r = '0;
        r.text_byte = has ? b : 8'h00;
        r.has = has;
        if (step_out.size() < 8)
            step_out.push_back(r);
    endfunction

    function automatic void drop_oldest();
        if (held_count == 0)
            return;
        emit_byte(held[0], 1'b1);
        for (int i = 1; i < held_count && i < SFR_MAX_LEN; i++)
            held[i - 1] = held[i];
        held_count--;
    endfunction

    function automatic void rewrite_step(input logic [7:0] b, input logic fin);
        int unsigned len;
        int unsigned rlen;
        bit          hit;
        result_t     r;
        step_out.delete();
        len = (find_len > SFR_MAX_LEN) ? SFR_MAX_LEN : find_len;
        rlen = (swap_len > 8) ? 8 : swap_len;
        if (held_count < SFR_MAX_LEN)
        begin
            held[held_count] = b;
            held_count++;
        end
        if (held_count > len)
        begin
            drop_oldest();
            if (held_count > len)
                drop_oldest();
        end
        else if (held_count == len && len > 0)
        begin
            hit = 1'b1;
            for (int i = 0; i < len; i++)
                if (held[i] != find_bytes[8*i +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                for (int i = 0; i < rlen; i++)
                    emit_byte(swap_bytes[8*i +: 8], 1'b1);
                held_count = 0;
                if (replaced_count != MATCH_MAX)
                    replaced_count++;
            end
            else
            begin
                drop_oldest();
            end
        end
        if (fin)
        begin
            while (held_count > 0)
                drop_oldest();
            if (step_out.size() == 0)
                emit_byte(8'h00, 1'b0);
        end
        for (int k = 0; k < step_out.size(); k++)
        begin
            r = step_out[k];
            r.fin = fin && (k == step_out.size() - 1);
            r.total = replaced_count;
            r.none = r.fin && (replaced_count == 0);
            step_out[k] = r;
        end
        if (fin)
            replaced_count = '0;
    endfunction

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SEARCH_PATTERN:     find_bytes = value;
            REG_SEARCH_LENGTH:      find_len = value[3:0];
            REG_REPLACEMENT_TEXT:   swap_bytes = value;
            REG_REPLACEMENT_LENGTH: swap_len = value[3:0];
        endcase
    endtask

    task automatic send_item(input logic [7:0] b, input logic fin,
                             input bit typed = 1'b0, input result_t fixed = '0);
        in_valid <= 1'b1;
        in_byte <= b;
        in_last <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        rewrite_step(b, fin);
        if (typed)
            expected_text.push_back(fixed);
        else
            foreach (step_out[k])
                expected_text.push_back(step_out[k]);
        if (!calm && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // The sender waits here until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_text(input int n, input bit close);
        logic [7:0]  text[$];
        int unsigned plen;
        int          r;
        int          pick;
        plen = (find_len > SFR_MAX_LEN) ? SFR_MAX_LEN : find_len;
        while (text.size() < n)
        begin
            r = $urandom_range(0, 99);
            if (plen > 0 && r < 30)
            begin
                for (int i = 0; i < plen; i++)
                    text.push_back(find_bytes[8*i +: 8]);
            end
            else if (plen > 0 && r < 70)
            begin
                pick = $urandom_range(0, plen - 1);
                text.push_back(find_bytes[8*pick +: 8]);
            end
            else
            begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        for (int i = 0; i < n; i++)
            send_item(text[i], close && (i == n - 1));
    endtask

    function automatic logic [3:0] pick_len();
        case ($urandom_range(0, 9))
            0:       return 4'd0;
            1:       return 4'd8;
            2:       return 4'($urandom_range(9, 15));
            default: return 4'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic randomise_settings();
        logic [63:0] pattern;
        if ($urandom_range(0, 3) == 0)
        begin
            pattern = {$urandom, $urandom};
        end
        else
        begin
            for (int i = 0; i < 8; i++)
                pattern[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
        end
        write_reg(REG_SEARCH_PATTERN, pattern);
        write_reg(REG_SEARCH_LENGTH, {60'd0, pick_len()});
        write_reg(REG_REPLACEMENT_TEXT, {$urandom, $urandom});
        write_reg(REG_REPLACEMENT_LENGTH, {60'd0, pick_len()});
    endtask

    function automatic void add_write(input reg_idx_t idx, input logic [63:0] value);
        step_t s;
        s = '{STEP_WRITE, idx, value, 8'h00, 1'b0, 1'b0, '0};
        directed.push_back(s);
    endfunction

    function automatic void add_byte(input logic [7:0] b, input logic fin);
        step_t s;
        s = '{STEP_BYTE, REG_SEARCH_PATTERN, 64'd0, b, fin, 1'b0, '0};
        directed.push_back(s);
    endfunction

    function automatic void add_typed(input logic [7:0] b, input logic fin,
                                      input result_t fixed);
        step_t s;
        s = '{STEP_BYTE, REG_SEARCH_PATTERN, 64'd0, b, fin, 1'b1, fixed};
        directed.push_back(s);
    endfunction

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        in_byte = 8'h00;
        in_last = 1'b0;
        out_ready = 1'b0;
        mismatches = 0;
        items_sent = 0;
        cycles = 0;
        hold_left = 0;
        hold_asked = 1'b0;
        calm = 1'b0;
        for (int i = 0; i < SFR_MAX_LEN; i++)
            held[i] = 8'h00;
        held_count = 0;
        replaced_count = '0;
        find_bytes = '0;
        find_len = '0;
        swap_bytes = '0;
        swap_len = '0;

        // After reset the pattern is empty, so bytes pass straight through.
        add_typed(8'h00, 1'b0, '{8'h00, 1'b1, 1'b0, 16'd0, 1'b0});
        add_typed(8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1, 16'd0, 1'b1});
        add_write(REG_SEARCH_PATTERN, 64'h6261);
        add_write(REG_SEARCH_LENGTH, 64'd2);
        add_write(REG_REPLACEMENT_TEXT, 64'h5A5958);
        add_write(REG_REPLACEMENT_LENGTH, 64'd3);
        add_byte(8'h61, 1'b0);
        add_byte(8'h62, 1'b0);
        add_byte(8'h61, 1'b0);
        add_byte(8'h61, 1'b0);
        add_byte(8'h62, 1'b0);
        add_byte(8'h63, 1'b1);
        // A deleted match on the last byte leaves only the empty end marker.
        add_write(REG_SEARCH_PATTERN, 64'h51);
        add_write(REG_SEARCH_LENGTH, 64'd1);
        add_write(REG_REPLACEMENT_LENGTH, 64'd0);
        add_typed(8'h51, 1'b1, '{8'h00, 1'b0, 1'b1, 16'd1, 1'b0});
        // Oversized lengths are clamped to eight bytes.
        add_write(REG_SEARCH_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
        add_write(REG_SEARCH_LENGTH, 64'd15);
        add_write(REG_REPLACEMENT_TEXT, 64'h0);
        add_write(REG_REPLACEMENT_LENGTH, 64'd15);
        for (int i = 0; i < 8; i++)
            add_byte(8'hFF, i == 7);
        // The pattern is shortened while the window still holds part of a text.
        add_write(REG_SEARCH_PATTERN, 64'h6463_6261);
        add_write(REG_SEARCH_LENGTH, 64'd4);
        add_write(REG_REPLACEMENT_TEXT, 64'h21);
        add_write(REG_REPLACEMENT_LENGTH, 64'd1);
        add_byte(8'h61, 1'b0);
        add_byte(8'h62, 1'b0);
        add_byte(8'h63, 1'b0);
        add_write(REG_SEARCH_LENGTH, 64'd1);
        add_byte(8'h7A, 1'b0);
        add_byte(8'h61, 1'b0);
        add_byte(8'h62, 1'b1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == STEP_WRITE)
            begin
                drain();
                write_reg(directed[i].idx, directed[i].value);
            end
            else
            begin
                send_item(directed[i].text_byte, directed[i].fin,
                          directed[i].typed, directed[i].want);
            end
        end

        phase = 0;
        base = items_sent;
        while (items_sent - base < RANDOM_REQUESTS)
        begin
            drain();
            calm = (phase == 4);
            if (phase == 0 || $urandom_range(0, 3) != 0)
                randomise_settings();
            if (phase == 6)
                hold_asked = 1'b1;
            repeat ($urandom_range(1, 4))
                send_text($urandom_range(1, 24), $urandom_range(0, 5) != 0);
            phase++;
        end

        drain();
        if (mismatches == 0)
            $display("PASS stream_find_replace_core");
        else
            $display("FAIL stream_find_replace_core");
        $finish;
    end

endmodule
